@@ sv/fsc_pkg.sv @@
// ----------------------------------------------------------------------------
// fsc_pkg
// Shared types and codes of the stack calculator.
// ----------------------------------------------------------------------------
package fsc_pkg;

	typedef enum logic [3:0] {
		OP_PUSH  = 4'd0,
		OP_ADD   = 4'd1,
		OP_SUB   = 4'd2,
		OP_MUL   = 4'd3,
		OP_DIV   = 4'd4,
		OP_MOD   = 4'd5,
		OP_PRINT = 4'd6,
		OP_DUP   = 4'd7,
		OP_DROP  = 4'd8,
		OP_SWAP  = 4'd9,
		OP_OVER  = 4'd10,
		OP_ROT   = 4'd11
	} op_t;

	typedef enum logic [1:0] {
		ERR_OK    = 2'd0,
		ERR_UNDER = 2'd1,
		ERR_OVER  = 2'd2,
		ERR_DIVZ  = 2'd3
	} err_t;

	// Cell shift commands: every cell gets the same one in a cycle; a direct write overrides it.
	typedef enum logic [1:0] {
		SH_HOLD = 2'd0,
		SH_PUSH = 2'd1,
		SH_POP  = 2'd2
	} shift_t;

	// Control handed from the sequencer to the row of cells.
	typedef struct packed {
		shift_t      shift;
		logic        wr_top;
		logic [31:0] top_val;
		logic        wr_sec;
		logic [31:0] sec_val;
		logic        wr_thd;
		logic [31:0] thd_val;
	} cell_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_DIV  = 2'd1,
		ST_OUT  = 2'd2
	} state_t;

endpackage

@@ sv/fsc_if.sv @@
// ----------------------------------------------------------------------------
// fsc_in_if / fsc_out_if
// Valid/ready channels for commands and results.
// ----------------------------------------------------------------------------
interface fsc_in_if;
	logic        valid;
	logic        ready;
	logic [3:0]  op;
	logic signed [31:0] value;
	modport source (output valid, output op, output value, input ready);
	modport sink (input valid, input op, input value, output ready);
endinterface

interface fsc_out_if;
	logic        valid;
	logic        ready;
	logic signed [31:0] out_value;
	logic        printed;
	logic [1:0]  error;
	logic [4:0]  depth;
	modport source (output valid, output out_value, output printed, output error,
		output depth, input ready);
	modport sink (input valid, input out_value, input printed, input error,
		input depth, output ready);
endinterface

@@ sv/fsc_cell.sv @@
// ----------------------------------------------------------------------------
// fsc_cell
// One stack entry. Shifts toward the bottom on push (from above), toward the top on pop (from below).
// ----------------------------------------------------------------------------
module fsc_cell (
	input  logic        clk,
	input  fsc_pkg::shift_t shift,
	input  logic [31:0] above,
	input  logic [31:0] below,
	input  logic        wr,
	input  logic [31:0] wr_val,
	output logic [31:0] data
);
	logic [31:0] data_q;

	// Index 0 is the top of stack. Push moves data deeper (from above),
	// pop moves it up (from below). A direct write wins over shifting.
	always_ff @(posedge clk) begin
		if (wr) begin
			data_q <= wr_val;
		end else begin
			case (shift)
				fsc_pkg::SH_PUSH: data_q <= above;
				fsc_pkg::SH_POP:  data_q <= below;
				default:          data_q <= data_q;
			endcase
		end
	end

	assign data = data_q;
endmodule

@@ sv/fsc_divider.sv @@
// ----------------------------------------------------------------------------
// fsc_divider
// Signed restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fsc_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] quot,
	output logic [31:0] rem
);
	logic [31:0] rem_q, quo_q, dsr_q;
	logic [5:0]  cnt_q;
	logic        busy_q, done_q, nq_q, nr_q;
	logic [32:0] trial;
	logic [31:0] shifted;

	assign shifted = {rem_q[30:0], quo_q[31]};
	assign trial   = {1'b0, shifted} - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend[31] ? 32'd0 - dividend : dividend;
			dsr_q <= divisor[31] ? 32'd0 - divisor : divisor;
			nq_q  <= dividend[31] ^ divisor[31];
			nr_q  <= dividend[31];
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = nq_q ? 32'd0 - quo_q : quo_q;
	assign rem  = nr_q ? 32'd0 - rem_q : rem_q;
endmodule

@@ sv/forth_stack_calculator_core.sv @@
// ----------------------------------------------------------------------------
// forth_stack_calculator_core
// Forth-style data-stack calculator built from a row of shifting cells.
// ----------------------------------------------------------------------------
// One command beat is taken at a time. The stack lives in a chain of cells
// whose first cell is the top of stack, so push, pop and the rearranging
// words only touch the top three cells while the rest of the chain shifts
// along. Push, arithmetic other than divide, print and the stack words update
// the cells at the accept edge and present the result beat in the next cycle,
// so with a ready receiver one command is taken every cycle. Divide and
// remainder run the one-bit-per-cycle divider: its 32 steps and its done
// strobe come before the result beat, and no command is taken while it
// runs. The result sits in an output register until it is taken, and the
// next command is accepted in the same cycle the result leaves. Failed
// commands leave the stack unchanged and report an error code.
// ----------------------------------------------------------------------------
module forth_stack_calculator_core #(
	parameter int STACK_DEPTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	fsc_in_if.sink    cmd,
	fsc_out_if.source res
);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	fsc_pkg::state_t  state_q, state_d;
	fsc_pkg::cell_ctl_t ctl;
	logic [CW-1:0] count_q, count_d;
	logic [31:0]   cell_data [STACK_DEPTH];
	logic [31:0]   a, b, c;
	logic          div_start, div_done, mod_q;
	logic [31:0]   quot, rem;
	logic [31:0]   outv_q, outv_d;
	logic          prn_q, prn_d;
	fsc_pkg::err_t err_q, err_d;
	logic          acc;
	fsc_pkg::op_t  op;
	logic [1:0]    need;
	logic          grow;

	assign a  = cell_data[0];
	assign b  = cell_data[1];
	assign c  = cell_data[2];
	assign op = fsc_pkg::op_t'(cmd.op);
	assign cmd.ready = (state_q == fsc_pkg::ST_IDLE) ||
		(state_q == fsc_pkg::ST_OUT && res.ready);
	assign acc = cmd.valid && cmd.ready;

	// The chain of cells; cell 0 is the top of stack.
	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		logic [31:0] above, below;
		logic        wr;
		logic [31:0] wv;
		if (i == 0) begin : g_top
			assign above = ctl.top_val;
			assign wr = ctl.wr_top;
			assign wv = ctl.top_val;
		end else if (i == 1) begin : g_sec
			assign above = cell_data[i-1];
			assign wr = ctl.wr_sec;
			assign wv = ctl.sec_val;
		end else if (i == 2) begin : g_thd
			assign above = cell_data[i-1];
			assign wr = ctl.wr_thd;
			assign wv = ctl.thd_val;
		end else begin : g_mid
			assign above = cell_data[i-1];
			assign wr = 1'b0;
			assign wv = '0;
		end
		if (i == STACK_DEPTH - 1) begin : g_last
			assign below = cell_data[i];
		end else begin : g_more
			assign below = cell_data[i+1];
		end
		fsc_cell u_cell (
			.clk(clk), .shift(ctl.shift), .above(above), .below(below),
			.wr(wr), .wr_val(wv), .data(cell_data[i])
		);
	end

	fsc_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(a), .divisor(b), .done(div_done), .quot(quot), .rem(rem)
	);

	always_comb begin
		case (op)
			fsc_pkg::OP_ADD, fsc_pkg::OP_SUB, fsc_pkg::OP_MUL, fsc_pkg::OP_DIV,
			fsc_pkg::OP_MOD, fsc_pkg::OP_SWAP, fsc_pkg::OP_OVER: need = 2'd2;
			fsc_pkg::OP_PRINT, fsc_pkg::OP_DUP, fsc_pkg::OP_DROP: need = 2'd1;
			fsc_pkg::OP_ROT: need = 2'd3;
			default: need = 2'd0;
		endcase
		grow = (op == fsc_pkg::OP_PUSH) || (op == fsc_pkg::OP_DUP) ||
			(op == fsc_pkg::OP_OVER);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fsc_pkg::ST_IDLE, fsc_pkg::ST_OUT: begin
				if (acc) begin
					if (count_q >= CW'(need) && b != 32'd0 &&
						(op == fsc_pkg::OP_DIV || op == fsc_pkg::OP_MOD))
						state_d = fsc_pkg::ST_DIV;
					else
						state_d = fsc_pkg::ST_OUT;
				end else if (state_q == fsc_pkg::ST_OUT && res.ready) begin
					state_d = fsc_pkg::ST_IDLE;
				end
			end
			fsc_pkg::ST_DIV: if (div_done) state_d = fsc_pkg::ST_OUT;
			default: state_d = fsc_pkg::ST_IDLE;
		endcase
	end

	// Cell commands, count and result fields.
	always_comb begin
		ctl = '{shift: fsc_pkg::SH_HOLD, wr_top: 1'b0, top_val: '0, wr_sec: 1'b0,
			sec_val: '0, wr_thd: 1'b0, thd_val: '0};
		count_d   = count_q;
		outv_d    = outv_q;
		prn_d     = prn_q;
		err_d     = err_q;
		div_start = 1'b0;
		if (state_q == fsc_pkg::ST_DIV) begin
			if (div_done) begin
				ctl.shift   = fsc_pkg::SH_POP;
				ctl.wr_top  = 1'b1;
				ctl.top_val = mod_q ? rem : quot;
				count_d     = count_q - CW'(1);
			end
		end else if (acc) begin
			outv_d = '0;
			prn_d  = 1'b0;
			err_d  = fsc_pkg::ERR_OK;
			if (count_q < CW'(need)) begin
				err_d = fsc_pkg::ERR_UNDER;
			end else if (grow && count_q >= CW'(STACK_DEPTH)) begin
				err_d = fsc_pkg::ERR_OVER;
			end else begin
				case (op)
					fsc_pkg::OP_PUSH, fsc_pkg::OP_DUP, fsc_pkg::OP_OVER: begin
						ctl.shift   = fsc_pkg::SH_PUSH;
						ctl.wr_top  = 1'b1;
						ctl.top_val = (op == fsc_pkg::OP_PUSH) ? cmd.value :
							(op == fsc_pkg::OP_DUP) ? a : b;
						count_d = count_q + CW'(1);
					end
					fsc_pkg::OP_ADD, fsc_pkg::OP_SUB, fsc_pkg::OP_MUL: begin
						ctl.shift   = fsc_pkg::SH_POP;
						ctl.wr_top  = 1'b1;
						ctl.top_val = (op == fsc_pkg::OP_ADD) ? a + b :
							(op == fsc_pkg::OP_SUB) ? a - b : a * b;
						count_d = count_q - CW'(1);
					end
					fsc_pkg::OP_DIV, fsc_pkg::OP_MOD: begin
						if (b == 32'd0) err_d = fsc_pkg::ERR_DIVZ;
						else div_start = 1'b1;
					end
					fsc_pkg::OP_PRINT, fsc_pkg::OP_DROP: begin
						ctl.shift = fsc_pkg::SH_POP;
						count_d   = count_q - CW'(1);
						if (op == fsc_pkg::OP_PRINT) begin
							outv_d = a;
							prn_d  = 1'b1;
						end
					end
					fsc_pkg::OP_SWAP: begin
						ctl.wr_top = 1'b1; ctl.top_val = b;
						ctl.wr_sec = 1'b1; ctl.sec_val = a;
					end
					fsc_pkg::OP_ROT: begin
						ctl.wr_top = 1'b1; ctl.top_val = c;
						ctl.wr_sec = 1'b1; ctl.sec_val = a;
						ctl.wr_thd = 1'b1; ctl.thd_val = b;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fsc_pkg::ST_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		outv_q <= outv_d;
		prn_q  <= prn_d;
		err_q  <= err_d;
		if (div_start) mod_q <= (op == fsc_pkg::OP_MOD);
	end

	assign res.valid     = (state_q == fsc_pkg::ST_OUT);
	assign res.out_value = outv_q;
	assign res.printed   = prn_q;
	assign res.error     = err_q;
	assign res.depth     = 5'(count_q);
endmodule

@@ sv/fsc_checker.sv @@
// ----------------------------------------------------------------------------
// fsc_checker
// Port-level checks of the stack calculator, bound to the top level.
// ----------------------------------------------------------------------------
module fsc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cmd_valid,
	input logic        cmd_ready,
	input logic        res_valid,
	input logic        res_ready,
	input logic        res_printed,
	input logic [1:0]  res_error,
	input logic [31:0] res_out_value,
	input logic [4:0]  res_depth
);
	// A stalled result beat holds its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable({res_out_value, res_printed,
		res_error, res_depth})) else $error("result changed while stalled");

	// A pending result that is not taken blocks new commands.
	a_block: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |-> !cmd_ready) else $error("accept while blocked");

	// Only a clean command prints.
	a_prn: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_printed |-> res_error == fsc_pkg::ERR_OK)
		else $error("print with error");

	// Non-print results carry a zero value.
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_printed |-> res_out_value == 32'd0)
		else $error("stray output value");
endmodule

bind forth_stack_calculator_core fsc_checker u_fsc_checker (
	.clk(clk), .arst_n(arst_n), .cmd_valid(cmd.valid), .cmd_ready(cmd.ready),
	.res_valid(res.valid), .res_ready(res.ready), .res_printed(res.printed),
	.res_error(res.error), .res_out_value(res.out_value), .res_depth(res.depth)
);

@@ bench/forth_stack_calculator_core_tb.sv @@
// ----------------------------------------------------------------------------
// forth_stack_calculator_core_tb
// Self-checking bench for the stack calculator core.
// ----------------------------------------------------------------------------
// Commands are driven on the command channel and every result beat is checked
// against a behavioral stack kept in a small scoreboard class. A directed
// opening covers each operation, underflow, overflow, divide by zero, the
// most negative dividend over minus one and an unused op code. Random command streams
// follow, biased so the stack depth wanders over its whole range.
// ----------------------------------------------------------------------------
module forth_stack_calculator_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STACK_DEPTH = 16;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		logic signed [31:0] out_value;
		logic               printed;
		fsc_pkg::err_t      error;
		logic [4:0]         depth;
	} calc_result_t;

	// The scoreboard tracks the stack contents and a queue of results still owed.
	class calc_scoreboard;
		logic [31:0]  cells[STACK_DEPTH];
		int           count;
		calc_result_t owed[$];
		int           mismatches;
		int           checked;

		function void note_command(logic [3:0] op, logic [31:0] lit);
			calc_result_t r;
			int need;
			logic signed [31:0] a, b, c;
			logic [31:0] q;
			r.out_value = '0;
			r.printed = 1'b0;
			r.error = fsc_pkg::ERR_OK;
			case (op)
				fsc_pkg::OP_ADD, fsc_pkg::OP_SUB, fsc_pkg::OP_MUL, fsc_pkg::OP_DIV,
				fsc_pkg::OP_MOD, fsc_pkg::OP_SWAP, fsc_pkg::OP_OVER: need = 2;
				fsc_pkg::OP_PRINT, fsc_pkg::OP_DUP, fsc_pkg::OP_DROP: need = 1;
				fsc_pkg::OP_ROT: need = 3;
				default: need = 0;
			endcase
			a = count >= 1 ? cells[count-1] : '0;
			b = count >= 2 ? cells[count-2] : '0;
			c = count >= 3 ? cells[count-3] : '0;
			if (count < need) begin
				r.error = fsc_pkg::ERR_UNDER;
			end else if ((op == fsc_pkg::OP_PUSH || op == fsc_pkg::OP_DUP ||
					op == fsc_pkg::OP_OVER) && count >= STACK_DEPTH) begin
				r.error = fsc_pkg::ERR_OVER;
			end else begin
				case (op)
					fsc_pkg::OP_PUSH: begin cells[count] = lit; count++; end
					fsc_pkg::OP_ADD: begin cells[count-2] = a + b; count--; end
					fsc_pkg::OP_SUB: begin cells[count-2] = a - b; count--; end
					fsc_pkg::OP_MUL: begin cells[count-2] = a * b; count--; end
					fsc_pkg::OP_DIV, fsc_pkg::OP_MOD: begin
						if (b == 0) begin
							r.error = fsc_pkg::ERR_DIVZ;
						end else begin
							// The most negative value over minus one wraps.
							if (a == 32'sh8000_0000 && b == -1)
								q = (op == fsc_pkg::OP_DIV) ? 32'h8000_0000 : 32'h0;
							else
								q = (op == fsc_pkg::OP_DIV) ? a / b : a % b;
							cells[count-2] = q;
							count--;
						end
					end
					fsc_pkg::OP_PRINT: begin
						r.out_value = a;
						r.printed = 1'b1;
						count--;
					end
					fsc_pkg::OP_DUP: begin cells[count] = a; count++; end
					fsc_pkg::OP_DROP: count--;
					fsc_pkg::OP_SWAP: begin cells[count-1] = b; cells[count-2] = a; end
					fsc_pkg::OP_OVER: begin cells[count] = b; count++; end
					fsc_pkg::OP_ROT: begin
						cells[count-3] = b;
						cells[count-2] = a;
						cells[count-1] = c;
					end
					default: ;
				endcase
			end
			r.depth = count[4:0];
			owed.push_back(r);
		endfunction

		function void check_result(logic signed [31:0] v, logic p, logic [1:0] e,
				logic [4:0] d);
			calc_result_t x;
			checked++;
			if (owed.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result beat with nothing owed: value %0d depth %0d", v, d);
				return;
			end
			x = owed.pop_front();
			if (v !== x.out_value || p !== x.printed || e !== x.error || d !== x.depth)
					begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch at result %0d: exp v=%0d p=%0b e=%0d d=%0d, ",
						checked, x.out_value, x.printed, x.error, x.depth,
						"got v=%0d p=%0b e=%0d d=%0d", v, p, e, d);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	fsc_in_if  cmd ();
	fsc_out_if res ();

	forth_stack_calculator_core #(.STACK_DEPTH(STACK_DEPTH)) uut (
		.clk(clk), .arst_n(arst_n), .cmd(cmd.sink), .res(res.source));

	calc_scoreboard board = new();
	int send_idle_pct;
	int take_idle_pct;
	int cycles;
	int sent;

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	// Every accepted command is noted and every accepted result checked at the
	// rising edge, when both handshakes are settled.
	always @(posedge clk) begin
		if (arst_n && cmd.valid && cmd.ready)
			board.note_command(cmd.op, cmd.value);
		if (arst_n && res.valid && res.ready)
			board.check_result(res.out_value, res.printed, res.error, res.depth);
	end

	// The receiver stalls at random, changing ready only at the falling edge.
	always @(negedge clk)
		res.ready <= ($urandom_range(99) >= take_idle_pct);

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("forth_stack_calculator_core_tb NOT OK");
			$finish;
		end
	end

	// Drives one command beat, with random idle cycles ahead of it.
	task automatic send_command(fsc_pkg::op_t op, logic [31:0] lit);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd.valid <= 1'b0;
			cmd.op <= 4'($urandom);
			cmd.value <= $urandom;
			@(negedge clk);
		end
		cmd.valid <= 1'b1;
		cmd.op <= op;
		cmd.value <= lit;
		@(posedge clk);
		while (!cmd.ready) @(posedge clk);
		sent++;
	endtask

	// Random literal with a bias toward the edges and small values.
	function automatic logic [31:0] pick_value();
		case ($urandom_range(5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			3: return 32'($urandom_range(4)) - 32'd2;
			default: return $urandom;
		endcase
	endfunction

	// Picks an op code; pushes dominate while the stack is shallow and pops
	// while it is nearly full, so both ends are visited again and again.
	task automatic send_random();
		int roll;
		logic [3:0] op;
		roll = $urandom_range(99);
		if (roll < 3)
			op = 4'($urandom_range(15, 12));
		else if (roll < 35 - board.count)
			op = fsc_pkg::OP_PUSH;
		else
			op = 4'($urandom_range(11));
		send_command(fsc_pkg::op_t'(op), pick_value());
	endtask

	task automatic run_phase(int send_pct, int take_pct, int items);
		send_idle_pct = send_pct;
		take_idle_pct = take_pct;
		repeat (items) send_random();
	endtask

	initial begin
		cycles = 0;
		sent = 0;
		send_idle_pct = 0;
		take_idle_pct = 0;
		cmd.valid = 1'b0;
		cmd.op = '0;
		cmd.value = '0;
		res.ready = 1'b0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed opening: underflow on an empty stack, then every word.
		send_command(fsc_pkg::OP_PRINT, 32'h0);
		send_command(fsc_pkg::OP_ADD, 32'h0);
		send_command(fsc_pkg::OP_PUSH, 32'h8000_0000);
		send_command(fsc_pkg::OP_ROT, 32'h0);
		send_command(fsc_pkg::OP_PUSH, 32'hffff_ffff);
		send_command(fsc_pkg::OP_DIV, 32'h0);
		send_command(fsc_pkg::OP_PUSH, 32'h8000_0000);
		send_command(fsc_pkg::OP_PUSH, 32'hffff_ffff);
		send_command(fsc_pkg::OP_SWAP, 32'h0);
		send_command(fsc_pkg::OP_MOD, 32'h0);
		send_command(fsc_pkg::OP_PUSH, 32'h0);
		send_command(fsc_pkg::OP_SWAP, 32'h0);
		send_command(fsc_pkg::OP_DIV, 32'h0);
		send_command(fsc_pkg::OP_OVER, 32'h0);
		send_command(fsc_pkg::OP_ROT, 32'h0);
		send_command(fsc_pkg::OP_MUL, 32'h0);
		send_command(fsc_pkg::OP_SUB, 32'h0);
		send_command(fsc_pkg::OP_DUP, 32'h7fff_ffff);
		send_command(fsc_pkg::op_t'(4'd15), 32'h5555_aaaa);
		send_command(fsc_pkg::OP_PRINT, 32'h0);
		send_command(fsc_pkg::OP_DROP, 32'h0);
		// Let the monitor note the last beat before the depth is read.
		#1;
		// Fill to the top, then overflow on push, dup and over.
		repeat (STACK_DEPTH - board.count) send_command(fsc_pkg::OP_PUSH, $urandom);
		send_command(fsc_pkg::OP_PUSH, 32'h1);
		send_command(fsc_pkg::OP_DUP, 32'h0);
		send_command(fsc_pkg::OP_OVER, 32'h0);

		run_phase(14, 48, 320);
		run_phase(48, 14, 320);
		run_phase(0, 0, 300);

		@(negedge clk);
		cmd.valid <= 1'b0;
		while (board.owed.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);

		$display("%0d commands sent, %0d result beats checked, %0d mismatches",
			sent, board.checked, board.mismatches);
		if (board.mismatches == 0)
			$display("forth_stack_calculator_core_tb OK");
		else
			$display("forth_stack_calculator_core_tb NOT OK");
		$finish;
	end
endmodule

@@ sim.f @@
sv/fsc_pkg.sv
sv/fsc_if.sv
sv/fsc_cell.sv
sv/fsc_divider.sv
sv/forth_stack_calculator_core.sv
sv/fsc_checker.sv
bench/forth_stack_calculator_core_tb.sv
